// ===== src/cbd_pkg.sv =====
// Shared types, codes and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package cbd_pkg;

    // Parser phase within one body
    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_SKIP       = 3'd1,
        PH_SKIP_CR    = 3'd2,
        PH_DIGITS     = 3'd3,
        PH_SIZE_LF    = 3'd4,
        PH_DATA       = 3'd5,
        PH_CHUNK_CR   = 3'd6,
        PH_CHUNK_LF   = 3'd7
    } phase_t;

    // Decode status codes
    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_DONE     = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_CRLF = 2'd3
    } status_t;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Hex digit decode: bit 4 set means not a hex digit, else bits 3:0 hold the value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                diff = c - 8'h30;
                hex_value = {1'b0, diff[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                diff = c - 8'h37;
                hex_value = {1'b0, diff[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                diff = c - 8'h57;
                hex_value = {1'b0, diff[3:0]};
            end else begin
                hex_value = 5'h10;
            end
        end
    endfunction

endpackage

// ===== src/chunked_body_decoder_core.sv =====
// Top level of the chunked body decoder: byte parser and result register.
`timescale 1ns / 1ps

// Decodes a chunk-encoded message body one byte per beat and returns one result beat
// for every input beat: the payload byte (zero when the byte was framing), a flag that
// it was payload, and the status after that byte (in progress, done, bad size line,
// missing CR LF after chunk data). Each byte is parsed by a single level of logic that
// writes the parser state and the result register at the same edge, so the block takes
// one byte every cycle as long as the result side keeps up; each result is registered. The
// result register lets a new byte in while the last result is being taken. Raise
// body_start on the first byte of each body. Errors and done hold until then.
module chunked_body_decoder_core #(
    parameter int MAX_SIZE_DIGITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] body_byte,
    input  logic       body_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       payload_valid,
    output logic [1:0] decode_status
);

    localparam int REM_W = 4 * MAX_SIZE_DIGITS;
    localparam int CNT_W = $clog2(MAX_SIZE_DIGITS + 1);

    cbd_pkg::phase_t  phase_reg, phase_next, cur_phase;
    cbd_pkg::status_t status_reg, status_next, cur_status;
    logic [REM_W-1:0] rem_reg, rem_next, cur_rem, rem_dec;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cur_cnt;

    logic       out_valid_reg;
    logic [7:0] pay_reg, pay_next;
    logic       pvalid_reg, pvalid_next;

    logic       accept;
    logic [4:0] hex;
    logic       is_hex;
    logic       room;

    // Accept when the result register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Body start clears the parser before this byte is parsed
    assign cur_phase  = body_start ? cbd_pkg::PH_LINE_START : phase_reg;
    assign cur_status = body_start ? cbd_pkg::ST_BUSY : status_reg;
    assign cur_rem    = body_start ? '0 : rem_reg;
    assign cur_cnt    = body_start ? '0 : cnt_reg;

    assign hex     = cbd_pkg::hex_value(body_byte);
    assign is_hex  = !hex[4];
    assign room    = cur_cnt < CNT_W'(MAX_SIZE_DIGITS);
    assign rem_dec = (cur_rem != '0) ? cur_rem - 1'b1 : cur_rem;

    // Next phase and status
    always_comb
    begin
        phase_next  = cur_phase;
        status_next = cur_status;
        if (cur_status == cbd_pkg::ST_BUSY)
        begin
            unique case (cur_phase)
                cbd_pkg::PH_LINE_START:
                begin
                    if (is_hex)
                        phase_next = cbd_pkg::PH_DIGITS;
                    else if (body_byte == cbd_pkg::CH_CR)
                        phase_next = cbd_pkg::PH_SKIP_CR;
                    else
                        phase_next = cbd_pkg::PH_SKIP;
                end
                cbd_pkg::PH_SKIP:
                begin
                    if (body_byte == cbd_pkg::CH_CR)
                        phase_next = cbd_pkg::PH_SKIP_CR;
                end
                cbd_pkg::PH_SKIP_CR:
                begin
                    if (body_byte == cbd_pkg::CH_LF)
                        phase_next = cbd_pkg::PH_DIGITS;
                    else if (body_byte != cbd_pkg::CH_CR)
                        phase_next = cbd_pkg::PH_SKIP;
                end
                cbd_pkg::PH_DIGITS:
                begin
                    if (is_hex && room)
                        phase_next = cbd_pkg::PH_DIGITS;
                    else if (body_byte == cbd_pkg::CH_CR)
                        phase_next = cbd_pkg::PH_SIZE_LF;
                    else
                        status_next = cbd_pkg::ST_BAD_SIZE;
                end
                cbd_pkg::PH_SIZE_LF:
                begin
                    if (body_byte != cbd_pkg::CH_LF)
                        status_next = cbd_pkg::ST_BAD_SIZE;
                    else if (cur_rem == '0)
                        status_next = cbd_pkg::ST_DONE;
                    else
                        phase_next = cbd_pkg::PH_DATA;
                end
                cbd_pkg::PH_DATA:
                begin
                    if (rem_dec == '0)
                        phase_next = cbd_pkg::PH_CHUNK_CR;
                end
                cbd_pkg::PH_CHUNK_CR:
                begin
                    if (body_byte == cbd_pkg::CH_CR)
                        phase_next = cbd_pkg::PH_CHUNK_LF;
                    else
                        status_next = cbd_pkg::ST_BAD_CRLF;
                end
                cbd_pkg::PH_CHUNK_LF:
                begin
                    if (body_byte == cbd_pkg::CH_LF)
                        phase_next = cbd_pkg::PH_LINE_START;
                    else
                        status_next = cbd_pkg::ST_BAD_CRLF;
                end
                default:
                begin
                    phase_next = cbd_pkg::PH_LINE_START;
                end
            endcase
        end
    end

    // Size accumulator, digit count and payload
    always_comb
    begin
        rem_next    = cur_rem;
        cnt_next    = cur_cnt;
        pay_next    = 8'h00;
        pvalid_next = 1'b0;
        if (cur_status == cbd_pkg::ST_BUSY)
        begin
            unique case (cur_phase)
                cbd_pkg::PH_LINE_START:
                begin
                    if (is_hex)
                    begin
                        rem_next = REM_W'(hex[3:0]);
                        cnt_next = CNT_W'(1);
                    end
                end
                cbd_pkg::PH_SKIP_CR:
                begin
                    if (body_byte == cbd_pkg::CH_LF)
                    begin
                        rem_next = '0;
                        cnt_next = '0;
                    end
                end
                cbd_pkg::PH_DIGITS:
                begin
                    if (is_hex && room)
                    begin
                        rem_next = (cur_rem << 4) | REM_W'(hex[3:0]);
                        cnt_next = cur_cnt + 1'b1;
                    end
                end
                cbd_pkg::PH_DATA:
                begin
                    pvalid_next = 1'b1;
                    pay_next    = body_byte;
                    rem_next    = rem_dec;
                end
                cbd_pkg::PH_CHUNK_LF:
                begin
                    if (body_byte == cbd_pkg::CH_LF)
                        cnt_next = '0;
                end
                default:
                begin
                    rem_next = cur_rem;
                end
            endcase
        end
    end

    // Advance parser state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cbd_pkg::PH_LINE_START;
            status_reg <= cbd_pkg::ST_BUSY;
            rem_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pay_reg    <= 8'h00;
            pvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            pay_reg    <= pay_next;
            pvalid_reg <= pvalid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = pay_reg;
    assign payload_valid = pvalid_reg;
    assign decode_status = status_reg;

endmodule
